@@ design/smb_pkg.sv @@
// shared constants and types for the sliding minimum background subtractor
`default_nettype none
package smb_pkg;

  localparam int unsigned BEHIND      = 250;
  localparam int unsigned AHEAD       = 249;
  localparam int unsigned RING_DEPTH  = 512;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned RING_AW     = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W       = 32;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_LAST   = 2'd1;
  localparam logic [1:0] MODE_DRAIN  = 2'd2;

  typedef struct packed {
    logic [1:0]             mode;
    logic [SAMPLE_BITS-1:0] sample;
  } smb_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] corrected;
    logic                   last;
  } smb_out_t;

  typedef struct packed {
    logic [RING_AW-1:0]     idx;
    logic [SAMPLE_BITS-1:0] val;
  } smb_dq_t;

  typedef struct packed {
    logic load;
    logic pop_tail;
    logic push;
    logic last;
    logic expire;
    logic emit;
  } smb_cmd_t;

  typedef struct packed {
    logic ended;
    logic pend_zero;
    logic pend_ge_ahead;
    logic tail_pop_ok;
    logic out_free;
  } smb_stat_t;

endpackage
`default_nettype wire

@@ design/sliding_min_background_subtract.sv @@
// top level of the sliding minimum background subtractor
// Usage:
// - input channel in_valid_i / in_ready_o carries one item per handshake:
//   mode sample, last sample of trace, or drain; mode 3 is dropped
// - output channel out_valid_o / out_ready_i carries corrected samples,
//   each the sample minus the minimum of the 250 before through 249 after
// - output for sample i appears after sample i+249 arrives; after the
//   end-marked sample each drain item yields one pending output, the
//   final one flagged by last, after which the trace counters restart
// - steps per item: a sample is loaded, entries not below it are popped
//   from the minimum queue tail (one per cycle through its read port) and
//   it is pushed; if an output is due, the head is expired and the result
//   emitted once the output register is free; a drain expires and emits
// - in_ready_o is high only while the sequencer is idle
// - the output register holds one result; while the receiver stalls the
//   next item is still taken and only stops at the point of emitting
// - reset clears counters, queue pointers and the output valid; the
//   sample and queue memories need no clearing, as their read data is
//   never used before being written within a trace
`default_nettype none
module sliding_min_background_subtract (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire smb_pkg::smb_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output smb_pkg::smb_out_t      out_data_o
);

  smb_pkg::smb_cmd_t  cmd;
  smb_pkg::smb_stat_t stat;

  smb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  smb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

@@ design/smb_ctrl.sv @@
// sequencing state machine for the sliding minimum background subtractor
`default_nettype none
module smb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_mode_i,
  output logic                   in_ready_o,
  input  wire smb_pkg::smb_stat_t stat_i,
  output smb_pkg::smb_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.last = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          priority if ((in_mode_i == smb_pkg::MODE_SAMPLE) ||
                       (in_mode_i == smb_pkg::MODE_LAST)) begin
            if (!stat_i.ended) begin
              state_d = S_POP;
              last_d  = (in_mode_i == smb_pkg::MODE_LAST);
            end
          end else if (in_mode_i == smb_pkg::MODE_DRAIN) begin
            if (stat_i.ended && !stat_i.pend_zero) begin
              state_d = S_WAIT;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_POP: begin
        if (stat_i.tail_pop_ok) begin
          cmd_o.pop_tail = 1'b1;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = stat_i.pend_ge_ahead ? S_WAIT : S_IDLE;
        end
      end
      S_WAIT: begin
        cmd_o.expire = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

endmodule
`default_nettype wire

@@ design/smb_datapath.sv @@
// sample ring, monotonic minimum queue, counters and output register
`default_nettype none
module smb_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire smb_pkg::smb_in_t   in_data_i,
  input  wire smb_pkg::smb_cmd_t  cmd_i,
  output smb_pkg::smb_stat_t      stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output smb_pkg::smb_out_t       out_data_o
);

  localparam int unsigned AW = smb_pkg::RING_AW;
  localparam int unsigned SB = smb_pkg::SAMPLE_BITS;
  localparam int unsigned CW = smb_pkg::CNT_W;
  localparam logic [CW-1:0] EXP_START = CW'(smb_pkg::BEHIND + 1);
  localparam logic [CW-1:0] PEND_MAX  = CW'(smb_pkg::AHEAD + 1);
  localparam logic [AW-1:0] OCC_MAX   = AW'(smb_pkg::BEHIND + smb_pkg::AHEAD + 2);

  logic [SB-1:0]     ring_mem [smb_pkg::RING_DEPTH];
  smb_pkg::smb_dq_t  dq_mem   [smb_pkg::RING_DEPTH];

  logic [SB-1:0]     s_q;
  logic [SB-1:0]     ring_rd_q;
  smb_pkg::smb_dq_t  tail_rd_q, head_rd_q;
  logic [AW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]     rcv_q, rcv_d, emit_q, emit_d;
  logic              ended_q, ended_d;
  logic              out_valid_q, out_valid_d;
  smb_pkg::smb_out_t out_data_q;

  logic [CW-1:0]     pending;
  logic [CW-1:0]     exp_full;
  logic [AW-1:0]     occ;
  logic              exp_hit;
  logic              fin;

  assign pending  = rcv_q - emit_q;
  assign exp_full = emit_q - EXP_START;
  assign occ      = tail_q - head_q;
  assign fin      = ended_q && (pending == CW'(1));
  assign exp_hit  = (emit_q >= EXP_START) && (head_rd_q.idx == exp_full[AW-1:0]) &&
                    (occ > AW'(1));

  assign stat_o.ended         = ended_q;
  assign stat_o.pend_zero     = (pending == '0);
  assign stat_o.pend_ge_ahead = (pending >= CW'(smb_pkg::AHEAD));
  assign stat_o.tail_pop_ok   = (tail_q != head_q) && (tail_rd_q.val >= s_q);
  assign stat_o.out_free      = !out_valid_q || out_ready_i;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    rcv_d       = rcv_q;
    emit_d      = emit_q;
    ended_d     = ended_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.pop_tail) begin
      tail_d = tail_q - AW'(1);
    end
    if (cmd_i.push) begin
      tail_d = tail_q + AW'(1);
      rcv_d  = rcv_q + CW'(1);
      if (cmd_i.last) begin
        ended_d = 1'b1;
      end
    end
    if (cmd_i.expire && exp_hit) begin
      head_d = head_q + AW'(1);
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      if (fin) begin
        head_d  = '0;
        tail_d  = '0;
        rcv_d   = '0;
        emit_d  = '0;
        ended_d = 1'b0;
      end else begin
        emit_d = emit_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      rcv_q       <= '0;
      emit_q      <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      rcv_q       <= rcv_d;
      emit_q      <= emit_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q <= in_data_i.sample;
    end
    if (cmd_i.emit) begin
      out_data_q.corrected <= ring_rd_q - head_rd_q.val;
      out_data_q.last      <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      ring_mem[rcv_q[AW-1:0]] <= s_q;
    end
    ring_rd_q <= ring_mem[emit_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      dq_mem[tail_q] <= '{idx: rcv_q[AW-1:0], val: s_q};
    end
    tail_rd_q <= dq_mem[tail_d - AW'(1)];
    head_rd_q <= dq_mem[head_d];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OCC_MAX)
    else $error("min queue holds more entries than the window allows");

  a_pend_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending <= PEND_MAX)
    else $error("more samples pending than the lookahead allows");

  a_fin_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && fin) |=> (rcv_q == '0) && (emit_q == '0) && !ended_q &&
                            (head_q == tail_q))
    else $error("trace state not cleared after final item");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// testbench for the sliding minimum background subtractor: traces checked against a predictor
`timescale 1ns / 1ps
module tb_top;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 1200;
  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned RANDOM_ITEMS = 30;
  localparam int unsigned LONG_TRACE  = 260;
  localparam int unsigned HOLD_TRACE  = 8;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  smb_pkg::smb_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  smb_pkg::smb_out_t out_data_o;

  // predictor state
  logic [smb_pkg::SAMPLE_BITS-1:0] trace_ring [smb_pkg::RING_DEPTH];
  logic [smb_pkg::CNT_W-1:0]       rx_samples   = '0;
  logic [smb_pkg::CNT_W-1:0]       tx_samples   = '0;
  bit                              trace_closed = 1'b0;
  smb_pkg::smb_out_t               corrected_q [$];

  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          steady       = 1'b0;
  bit          hold_req     = 1'b0;

  sliding_min_background_subtract DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic void emit_corrected();
    logic [smb_pkg::CNT_W-1:0]       pos;
    logic [smb_pkg::CNT_W-1:0]       pending;
    logic [smb_pkg::CNT_W-1:0]       back;
    logic [smb_pkg::CNT_W-1:0]       fwd;
    logic [smb_pkg::CNT_W-1:0]       span;
    logic [smb_pkg::CNT_W-1:0]       idx;
    logic [smb_pkg::SAMPLE_BITS-1:0] floor_val;
    logic [smb_pkg::SAMPLE_BITS-1:0] v;
    smb_pkg::smb_out_t               res;
    pos     = tx_samples;
    pending = rx_samples - pos;
    back    = (pos < smb_pkg::BEHIND) ? pos : smb_pkg::BEHIND;
    fwd     = pending - 1;
    if (fwd > smb_pkg::AHEAD) begin
      fwd = smb_pkg::AHEAD;
    end
    span      = back + fwd + 1;
    floor_val = '1;
    for (int unsigned k = 0; k < span; k++) begin
      idx = pos - back + k;
      v   = trace_ring[idx[smb_pkg::RING_AW-1:0]];
      if (v < floor_val) begin
        floor_val = v;
      end
    end
    idx           = pos;
    res.corrected = trace_ring[idx[smb_pkg::RING_AW-1:0]] - floor_val;
    res.last      = trace_closed && (pending == 1);
    corrected_q.push_back(res);
    tx_samples = pos + 1;
    if (res.last) begin
      rx_samples   = '0;
      tx_samples   = '0;
      trace_closed = 1'b0;
    end
  endfunction

  function automatic void predict_item(smb_pkg::smb_in_t item);
    if (item.mode == smb_pkg::MODE_SAMPLE || item.mode == smb_pkg::MODE_LAST) begin
      if (!trace_closed) begin
        trace_ring[rx_samples[smb_pkg::RING_AW-1:0]] = item.sample;
        rx_samples = rx_samples + 1;
        if (item.mode == smb_pkg::MODE_LAST) begin
          trace_closed = 1'b1;
        end
        if (rx_samples - tx_samples > smb_pkg::AHEAD) begin
          emit_corrected();
        end
      end
    end else if (item.mode == smb_pkg::MODE_DRAIN) begin
      if (trace_closed && rx_samples != tx_samples) begin
        emit_corrected();
      end
    end
  endfunction

  function automatic smb_pkg::smb_in_t make_item(logic [1:0] mode,
                                                 logic [smb_pkg::SAMPLE_BITS-1:0] sample);
    smb_pkg::smb_in_t item;
    item.mode   = mode;
    item.sample = sample;
    return item;
  endfunction

  function automatic logic [smb_pkg::SAMPLE_BITS-1:0] rand_sample();
    logic [smb_pkg::SAMPLE_BITS-1:0] base;
    base = smb_pkg::SAMPLE_BITS'($urandom);
    case ($urandom_range(3))
      0: return base;
      1: return smb_pkg::SAMPLE_BITS'(1000 + $urandom_range(200));
      2: return $urandom_range(1) ? '1 : '0;
      default: return {8'hFF, base[7:0]};
    endcase
  endfunction

  task automatic send_item(smb_pkg::smb_in_t item);
    while (!steady && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(item);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (corrected_q.size() != 0);
  endtask

  task automatic close_trace();
    while (trace_closed) begin
      send_item(make_item(smb_pkg::MODE_DRAIN, rand_sample()));
    end
  endtask

  task automatic test_ignored_items();
    send_item(make_item(smb_pkg::MODE_DRAIN, 16'h1234));
    send_item(make_item(MODE_UNUSED, 16'hFFFF));
  endtask

  task automatic test_single_sample_trace();
    send_item(make_item(smb_pkg::MODE_LAST, 16'hFFFF));
    send_item(make_item(smb_pkg::MODE_SAMPLE, 16'h0000));
    send_item(make_item(smb_pkg::MODE_LAST, 16'h0000));
    send_item(make_item(smb_pkg::MODE_DRAIN, 16'h0000));
    send_item(make_item(smb_pkg::MODE_DRAIN, 16'h5555));
  endtask

  task automatic test_extreme_samples();
    send_item(make_item(smb_pkg::MODE_SAMPLE, 16'h0000));
    send_item(make_item(smb_pkg::MODE_SAMPLE, 16'hFFFF));
    send_item(make_item(smb_pkg::MODE_SAMPLE, 16'h8000));
    send_item(make_item(MODE_UNUSED, 16'h0000));
    send_item(make_item(smb_pkg::MODE_SAMPLE, 16'h7FFF));
    send_item(make_item(smb_pkg::MODE_SAMPLE, 16'h0001));
    send_item(make_item(smb_pkg::MODE_LAST, 16'hFFFE));
    repeat (3) send_item(make_item(smb_pkg::MODE_DRAIN, 16'hAAAA));
    send_item(make_item(MODE_UNUSED, 16'hFFFF));
    repeat (3) send_item(make_item(smb_pkg::MODE_DRAIN, 16'h0000));
  endtask

  task automatic test_random_traces();
    int unsigned sent;
    int unsigned len;
    bit          end_mark;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len      = ($urandom_range(7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
      end_mark = ($urandom_range(9) != 0);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(11) == 0) begin
          send_item(make_item($urandom_range(1) ? MODE_UNUSED : smb_pkg::MODE_DRAIN,
                              rand_sample()));
        end
        send_item(make_item((end_mark && i == len - 1) ? smb_pkg::MODE_LAST
                                                       : smb_pkg::MODE_SAMPLE,
                            rand_sample()));
        sent++;
      end
      while (trace_closed) begin
        if ($urandom_range(11) == 0) begin
          send_item(make_item($urandom_range(1) ? MODE_UNUSED : smb_pkg::MODE_SAMPLE,
                              rand_sample()));
        end
        send_item(make_item(smb_pkg::MODE_DRAIN, rand_sample()));
        sent++;
      end
      if ($urandom_range(5) == 0) begin
        send_item(make_item(smb_pkg::MODE_DRAIN, rand_sample()));
      end
      if ($urandom_range(15) == 0) begin
        wait_drained();
      end
    end
    send_item(make_item(smb_pkg::MODE_LAST, rand_sample()));
    close_trace();
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    for (int unsigned i = 0; i < HOLD_TRACE; i++) begin
      send_item(make_item((i == HOLD_TRACE - 1) ? smb_pkg::MODE_LAST : smb_pkg::MODE_SAMPLE,
                          rand_sample()));
    end
    close_trace();
    wait_drained();
  endtask

  // rising samples keep the oldest entry at the head so it ages out of the window
  task automatic test_long_trace();
    steady = 1'b1;
    for (int unsigned i = 0; i < LONG_TRACE; i++) begin
      send_item(make_item((i == LONG_TRACE - 1) ? smb_pkg::MODE_LAST : smb_pkg::MODE_SAMPLE,
                          smb_pkg::SAMPLE_BITS'(i * 200 + $urandom_range(150))));
    end
    close_trace();
    steady = 1'b0;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= steady || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk_i) begin
    smb_pkg::smb_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (corrected_q.size() == 0) begin
        $error("result with no item pending: corrected %0d last %0b",
               out_data_o.corrected, out_data_o.last);
        mismatch_cnt++;
      end else begin
        want = corrected_q.pop_front();
        if (out_data_o.corrected !== want.corrected) begin
          $error("corrected: expected %0d, got %0d", want.corrected, out_data_o.corrected);
          mismatch_cnt++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data_o.last);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("sliding_min_background_subtract: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ignored_items();
    test_single_sample_trace();
    test_extreme_samples();
    wait_drained();
    test_random_traces();
    test_output_backpressure();
    test_long_trace();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (corrected_q.size() != 0) begin
      $error("%0d results never arrived", corrected_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("sliding_min_background_subtract: match");
    end else begin
      $display("sliding_min_background_subtract: mismatch");
    end
    $finish;
  end

endmodule
